[src/ets_pkg.sv]
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types and constants for the extreme-tracking stack: data widths,
// operation and status codes, and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package ets_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_W       = 8;
   localparam int DEFAULT_DEPTH = 128;

   // Value reported for the top and the extreme of an empty stack.
   localparam logic signed [DATA_W-1:0] EMPTY_READ = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;
   localparam logic [1:0] FUNC_PEEK = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic take;     // latch the request payload
      logic exec;     // perform the operation on counts and memories
      logic finish;   // load the result register
   } ets_cmd_type;

   typedef struct packed {
      logic out_busy; // result register still holds an untaken result
   } ets_sts_type;

endpackage

[src/ets_ram.sv]
// ----------------------------------------------------------------------------
// ets_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ets_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ets_ctrl.sv]
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer for the extreme-tracking stack: takes one request, runs the
// operation, then hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module ets_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ets_pkg::ets_sts_type sts,
   output ets_pkg::ets_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[src/ets_dp.sv]
// ----------------------------------------------------------------------------
// ets_dp
// Datapath of the extreme-tracking stack: value and extreme memories, their
// counts, registered copies of both tops, the mode register and the result
// register.
// ----------------------------------------------------------------------------
module ets_dp #(
   parameter int DEPTH = ets_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ets_pkg::ets_cmd_type              cmd,
   output ets_pkg::ets_sts_type              sts,
   input  logic [1:0]                        req_func,
   input  logic signed [ets_pkg::DATA_W-1:0] req_value,
   input  logic                              csr_valid,
   input  logic                              csr_track_max,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ets_pkg::DATA_W-1:0] rsp_top_value,
   output logic signed [ets_pkg::DATA_W-1:0] rsp_extreme_value,
   output logic [ets_pkg::DEPTH_W-1:0]       rsp_depth_now,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic [1:0]                        rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = ets_pkg::DATA_W;
   localparam int XW = ets_pkg::DEPTH_W;

   logic [1:0]           func_ff, func_in;
   logic signed [DW-1:0] value_ff, value_in;
   logic [CW-1:0]        vcount_ff, vcount_in;
   logic [CW-1:0]        xcount_ff, xcount_in;
   logic signed [DW-1:0] top_ff, top_in;
   logic signed [DW-1:0] xtop_ff, xtop_in;
   logic                 load_top_ff, load_top_in;
   logic                 load_xtop_ff, load_xtop_in;
   logic [1:0]           status_ff, status_in;
   logic                 track_max_ff, track_max_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_top_ff, rsp_top_in;
   logic signed [DW-1:0] rsp_xtr_ff, rsp_xtr_in;
   logic [XW-1:0]        rsp_depth_ff, rsp_depth_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 vwr_en, xwr_en;
   logic [DW-1:0]        vrd_data, xrd_data;
   logic [CW-1:0]        vcount_m2, xcount_m2;
   logic [AW-1:0]        vrd_addr, xrd_addr;
   logic                 is_full, is_empty, aux_empty, goes_aux;
   logic [CW+XW-1:0]     depth_ext;
   logic signed [DW-1:0] top_nx, xtop_nx;

   assign is_full   = (vcount_ff == CW'(DEPTH));
   assign is_empty  = (vcount_ff == '0);
   assign aux_empty = (xcount_ff == '0);

   // A pushed value joins the auxiliary stack on a tie as well.
   assign goes_aux = aux_empty ||
                     (track_max_ff ? (value_ff >= xtop_ff) : (value_ff <= xtop_ff));

   // Entry just below the top, read while a pop executes.
   assign vcount_m2 = vcount_ff - CW'(2);
   assign xcount_m2 = xcount_ff - CW'(2);
   assign vrd_addr  = vcount_m2[AW-1:0];
   assign xrd_addr  = xcount_m2[AW-1:0];

   assign top_nx    = load_top_ff  ? DW'(vrd_data) : top_ff;
   assign xtop_nx   = load_xtop_ff ? DW'(xrd_data) : xtop_ff;
   assign depth_ext = {{XW{1'b0}}, vcount_ff};

   always_comb begin
      func_in       = func_ff;
      value_in      = value_ff;
      vcount_in     = vcount_ff;
      xcount_in     = xcount_ff;
      // The read data is valid only in the cycle after a pop executes, so the
      // new tops are captured then, whether or not the result can leave.
      top_in        = top_nx;
      xtop_in       = xtop_nx;
      load_top_in   = 1'b0;
      load_xtop_in  = 1'b0;
      status_in     = status_ff;
      track_max_in  = track_max_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_top_in    = rsp_top_ff;
      rsp_xtr_in    = rsp_xtr_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_status_in = rsp_status_ff;
      vwr_en        = 1'b0;
      xwr_en        = 1'b0;

      if (csr_valid) begin
         track_max_in = csr_track_max;
      end

      if (cmd.take) begin
         func_in  = req_func;
         value_in = req_value;
      end

      if (cmd.exec) begin
         status_in    = ets_pkg::STAT_DONE;
         load_top_in  = 1'b0;
         load_xtop_in = 1'b0;
         unique case (func_ff)
            ets_pkg::FUNC_PUSH: begin
               if (is_full) begin
                  status_in = ets_pkg::STAT_FULL;
               end else begin
                  vwr_en    = 1'b1;
                  vcount_in = vcount_ff + CW'(1);
                  top_in    = value_ff;
                  if (goes_aux) begin
                     xwr_en    = 1'b1;
                     xcount_in = xcount_ff + CW'(1);
                     xtop_in   = value_ff;
                  end
               end
            end
            ets_pkg::FUNC_POP: begin
               if (is_empty) begin
                  status_in = ets_pkg::STAT_EMPTY;
               end else begin
                  vcount_in   = vcount_ff - CW'(1);
                  load_top_in = (vcount_ff > CW'(1));
                  if (!aux_empty && (top_ff == xtop_ff)) begin
                     xcount_in    = xcount_ff - CW'(1);
                     load_xtop_in = (xcount_ff > CW'(1));
                  end
               end
            end
            default: begin
               // Peek and the unused code leave the stack as it is.
            end
         endcase
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_top_in    = is_empty  ? ets_pkg::EMPTY_READ : top_nx;
         rsp_xtr_in    = aux_empty ? ets_pkg::EMPTY_READ : xtop_nx;
         rsp_depth_in  = depth_ext[XW-1:0];
         rsp_empty_in  = is_empty;
         rsp_full_in   = is_full;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         xcount_ff    <= '0;
         track_max_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         xcount_ff    <= xcount_in;
         track_max_ff <= track_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      top_ff        <= top_in;
      xtop_ff       <= xtop_in;
      load_top_ff   <= load_top_in;
      load_xtop_ff  <= load_xtop_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_xtr_ff    <= rsp_xtr_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_status_ff <= rsp_status_in;
   end

   ets_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (vwr_en),
      .wr_addr (vcount_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_addr (vrd_addr),
      .rd_data (vrd_data)
   );

   ets_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_extreme_ram (
      .clock   (clock),
      .wr_en   (xwr_en),
      .wr_addr (xcount_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_addr (xrd_addr),
      .rd_data (xrd_data)
   );

   assign sts.out_busy      = rsp_valid_ff && rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_extreme_value = rsp_xtr_ff;
   assign rsp_depth_now     = rsp_depth_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_is_full       = rsp_full_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

[src/extreme_tracking_stack.sv]
// ----------------------------------------------------------------------------
// extreme_tracking_stack
// Bounded stack of signed values that tracks its running minimum or maximum.
// ----------------------------------------------------------------------------
// Each request (push, pop or peek) is taken in the idle state on its transfer;
// the execute state then updates the counts and the two memories, and the done
// state refreshes the registered tops from the registered memory read that a
// pop needs and loads the result register. The result is offered once the done
// state has loaded the result register, and req_stall stays high in the execute
// and done states, so no new request is taken until the last one has left the
// done state. A stalled result does not hold up the transfer and execution of
// the next request; that request then waits in the done state until the output
// register is free, and its wait adds the remaining stall time. The csr_track_max
// register selects maximum tracking when 1 and may be written at any time
// the block is idle; csr_ready is always high. Reset clears the counts, the
// mode register and the result valid, and a request can be taken as soon as
// reset is released.
// ----------------------------------------------------------------------------
module extreme_tracking_stack #(
   parameter int DEPTH = ets_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic signed [ets_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ets_pkg::DATA_W-1:0] rsp_top_value,
   output logic signed [ets_pkg::DATA_W-1:0] rsp_extreme_value,
   output logic [ets_pkg::DEPTH_W-1:0]       rsp_depth_now,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_track_max
);

   ets_pkg::ets_cmd_type cmd;
   ets_pkg::ets_sts_type sts;

   assign csr_ready = 1'b1;

   ets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ets_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_value         (req_value),
      .csr_valid         (csr_valid),
      .csr_track_max     (csr_track_max),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_top_value     (rsp_top_value),
      .rsp_extreme_value (rsp_extreme_value),
      .rsp_depth_now     (rsp_depth_now),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_status        (rsp_status)
   );

endmodule

[src/ets_checker.sv]
// ----------------------------------------------------------------------------
// ets_checker
// Port-level checks for the extreme-tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module ets_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [ets_pkg::DATA_W-1:0] rsp_top_value,
   input logic signed [ets_pkg::DATA_W-1:0] rsp_extreme_value,
   input logic [ets_pkg::DEPTH_W-1:0]       rsp_depth_now,
   input logic                              rsp_is_empty,
   input logic                              rsp_is_full,
   input logic [1:0]                        rsp_status
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // An empty stack has no entries and reports the empty marker for both values.
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |->
         (rsp_depth_now == '0) && !rsp_is_full &&
         (rsp_top_value == ets_pkg::EMPTY_READ) &&
         (rsp_extreme_value == ets_pkg::EMPTY_READ))
      else $error("empty result carries stale contents");

   // A dropped push can only happen on a full stack.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ets_pkg::STAT_FULL) |-> rsp_is_full)
      else $error("push dropped on a stack that is not full");

   // An ignored pop leaves the stack empty.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ets_pkg::STAT_EMPTY) |-> rsp_is_empty)
      else $error("pop ignored on a stack that is not empty");

endmodule

bind extreme_tracking_stack ets_checker u_ets_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_top_value     (rsp_top_value),
   .rsp_extreme_value (rsp_extreme_value),
   .rsp_depth_now     (rsp_depth_now),
   .rsp_is_empty      (rsp_is_empty),
   .rsp_is_full       (rsp_is_full),
   .rsp_status        (rsp_status)
);
